>>> rtl/mse_pkg.sv
// Package for the Morse symbol extractor: phase type, register map,
// configuration and result structures shared by every module.
// No dependencies.
package mse_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned ClockW   = 8;
  localparam int unsigned TotalW   = 4;
  localparam int unsigned BitsW    = 8;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] RegDitMax  = 3'd0;
  localparam logic [2:0] RegDahMin  = 3'd1;
  localparam logic [2:0] RegDahMax  = 3'd2;
  localparam logic [2:0] RegCharGap = 3'd3;
  localparam logic [2:0] RegWordGap = 3'd4;

  localparam logic [ThrW-1:0] DitMaxReset  = 8'd20;
  localparam logic [ThrW-1:0] DahMinReset  = 8'd20;
  localparam logic [ThrW-1:0] DahMaxReset  = 8'd80;
  localparam logic [ThrW-1:0] CharGapReset = 8'd40;
  localparam logic [ThrW-1:0] WordGapReset = 8'd100;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhHigh = 2'd1,
    PhLow  = 2'd2,
    PhChar = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ThrW-1:0] dit_max;
    logic [ThrW-1:0] dah_min;
    logic [ThrW-1:0] dah_max;
    logic [ThrW-1:0] char_gap;
    logic [ThrW-1:0] word_gap;
  } cfg_t;

  typedef struct packed {
    logic              char_done;
    logic              word_done;
    logic [TotalW-1:0] symbol_total;
    logic [BitsW-1:0]  symbol_bits;
  } result_t;

endpackage

>>> rtl/mse_cfg.sv
// Configuration registers of the Morse symbol extractor behind an APB-style port.
// Depends on mse_pkg for the register map and reset values.
module mse_cfg import mse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegDitMax:  cfg_d.dit_max  = pwdata[ThrW-1:0];
        RegDahMin:  cfg_d.dah_min  = pwdata[ThrW-1:0];
        RegDahMax:  cfg_d.dah_max  = pwdata[ThrW-1:0];
        RegCharGap: cfg_d.char_gap = pwdata[ThrW-1:0];
        RegWordGap: cfg_d.word_gap = pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegDitMax:  prdata = CfgDataW'(cfg_q.dit_max);
      RegDahMin:  prdata = CfgDataW'(cfg_q.dah_min);
      RegDahMax:  prdata = CfgDataW'(cfg_q.dah_max);
      RegCharGap: prdata = CfgDataW'(cfg_q.char_gap);
      RegWordGap: prdata = CfgDataW'(cfg_q.word_gap);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dit_max  <= DitMaxReset;
      cfg_q.dah_min  <= DahMinReset;
      cfg_q.dah_max  <= DahMaxReset;
      cfg_q.char_gap <= CharGapReset;
      cfg_q.word_gap <= WordGapReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/mse_core.sv
// Timing state and per-sample decode step of the Morse symbol extractor.
// Holds the phase, sample clock and symbol buffer; depends on mse_pkg.
module mse_core import mse_pkg::*; #(
  parameter int unsigned SYMBOL_SLOTS = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    clear_i,
  input  logic    level_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam int unsigned CntW  = $clog2(SYMBOL_SLOTS + 1);
  localparam int unsigned TotWW = (CntW > TotalW) ? CntW : TotalW;
  localparam int unsigned BitWW = (SYMBOL_SLOTS > BitsW) ? SYMBOL_SLOTS : BitsW;

  phase_e                  phase_q, phase_d;
  logic [ClockW-1:0]       clock_q, clock_d, clock_inc;
  logic [ClockW-1:0]       start_q, start_d;
  logic                    prev_q, prev_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    word_q, word_d;
  logic [SYMBOL_SLOTS-1:0] store_q, store_d;
  logic [ClockW-1:0]       elapsed;
  logic                    sym_ok, sym_dah, append;
  logic                    char_done;
  logic [SYMBOL_SLOTS-1:0] masked;
  logic [TotWW-1:0]        total_wide;
  logic [BitWW-1:0]        bits_wide;

  assign clock_inc = clock_q + ClockW'(1);
  // Both the high duration and the pause are measured from the same start mark.
  assign elapsed   = clock_inc - start_q;

  always_comb begin
    phase_d   = phase_q;
    clock_d   = clock_q;
    start_d   = start_q;
    prev_d    = prev_q;
    count_d   = count_q;
    word_d    = word_q;
    sym_ok    = 1'b0;
    sym_dah   = 1'b0;
    append    = 1'b0;
    char_done = 1'b0;
    if (clear_i) begin
      phase_d = PhIdle;
      start_d = '0;
      count_d = '0;
      word_d  = 1'b0;
    end else begin
      clock_d = clock_inc;
      prev_d  = level_i;
      if (level_i != prev_q) begin
        start_d = clock_inc;
        if (level_i) begin
          phase_d = PhHigh;
        end else begin
          phase_d = PhLow;
          if (phase_q == PhHigh) begin
            // A wrapped duration of zero is never a dit.
            if (elapsed != '0 && elapsed < cfg_i.dit_max) begin
              sym_ok = 1'b1;
            end else if (elapsed >= cfg_i.dah_min && elapsed < cfg_i.dah_max) begin
              sym_ok  = 1'b1;
              sym_dah = 1'b1;
            end else begin
              count_d = '0;
              phase_d = PhIdle;
              start_d = start_q;
            end
            // A symbol found with the buffer full is dropped.
            if (sym_ok && count_q < CntW'(SYMBOL_SLOTS)) begin
              append  = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end
        end
      end else if (phase_q == PhLow || phase_q == PhChar) begin
        if (elapsed >= cfg_i.char_gap && count_q != '0) begin
          word_d    = (elapsed >= cfg_i.word_gap);
          phase_d   = PhChar;
          char_done = 1'b1;
        end
      end
    end
  end

  always_comb begin
    store_d = store_q;
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      if (append && count_q == CntW'(i)) begin
        store_d[i] = sym_dah;
      end
    end
  end

  // Slots at or above the count read as dits so stale entries never leak out.
  always_comb begin
    for (int i = 0; i < SYMBOL_SLOTS; i++) begin
      masked[i] = store_d[i] && (CntW'(i) < count_d);
    end
  end

  assign total_wide = TotWW'(count_d);
  assign bits_wide  = BitWW'(masked);

  assign result_o.char_done    = char_done;
  assign result_o.word_done    = word_d;
  assign result_o.symbol_total = total_wide[TotalW-1:0];
  assign result_o.symbol_bits  = bits_wide[BitsW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      clock_q <= '0;
      start_q <= '0;
      prev_q  <= 1'b0;
      count_q <= '0;
      word_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      clock_q <= clock_d;
      start_q <= start_d;
      prev_q  <= prev_d;
      count_q <= count_d;
      word_q  <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

endmodule

>>> rtl/morse_symbol_extractor_top.sv
// Latency: a result is presented the cycle after its item is accepted.
// Throughput: one item per cycle; the decode step is a single registered pass
// from the timing state to the output register; input ready follows output ready.
// Reset clears the phase, sample clock, counts, word flag and output valid and
// loads the threshold registers with their defaults; the symbol buffer is not cleared.
// Top level of the Morse symbol extractor; depends on mse_pkg, mse_cfg, mse_core.
module morse_symbol_extractor_top import mse_pkg::*; #(
  parameter int unsigned SYMBOL_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] key_level, [7:1] zero
  input  logic [0:0]          s_axis_tuser,  // [0] action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] char_done, [1] word_done, [5:2] symbol_total, [13:6] symbol_bits, [15:14] zero
  output logic [15:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  result_t result;
  result_t out_q;
  logic    out_valid_q;
  logic    in_accept;

  mse_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mse_core #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_accept),
    .clear_i  (s_axis_tuser[0]),
    .level_i  (s_axis_tdata[0]),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // The output register takes a new item whenever it is empty or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.symbol_bits, out_q.symbol_total,
                          out_q.word_done, out_q.char_done};

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted item produced no result");

  a_clear_all_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && s_axis_tuser[0]) |=> (out_q == '0))
    else $error("clear item gave a non-zero result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty output register");
`endif

endmodule

>>> sim/mse_checker.sv
// Scoreboard for the Morse symbol extractor: follows the key-sample stream, the
// result stream and the APB port, predicts every result and counts mismatches.
// Depends on mse_pkg.
module mse_checker import mse_pkg::*; #(
  parameter int unsigned SYMBOL_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] key_level, [7:1] zero
  input  logic [0:0]          s_axis_tuser,  // [0] action
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] char_done, [1] word_done, [5:2] symbol_total, [13:6] symbol_bits, [15:14] zero
  input  logic [15:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  input  logic [CfgDataW-1:0] prdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  pending_o
);

  cfg_t              thr;
  phase_e            key_phase;
  logic [ClockW-1:0] sample_clk;
  logic [ClockW-1:0] phase_start;
  logic              prev_level;
  logic              word_flag;
  logic [4:0]        n_symbols;
  logic [15:0]       slots;
  result_t           awaited_reports[$];
  int                fails;

  function automatic result_t report(input logic char_flag);
    result_t r;
    r.char_done    = char_flag;
    r.word_done    = word_flag;
    r.symbol_total = n_symbols[TotalW-1:0];
    for (int i = 0; i < BitsW; i++) begin
      r.symbol_bits[i] = (i < n_symbols) ? slots[i] : 1'b0;
    end
    return r;
  endfunction

  // Advances the timing state by one item and returns the report it produces.
  function automatic result_t decode_sample(input logic is_clear, input logic level);
    logic [ClockW-1:0] span;
    logic              char_flag;
    logic              rejected;
    logic              is_dah;
    char_flag = 1'b0;
    rejected  = 1'b0;
    is_dah    = 1'b0;
    if (is_clear) begin
      key_phase   = PhIdle;
      phase_start = '0;
      n_symbols   = '0;
      word_flag   = 1'b0;
      return report(1'b0);
    end
    sample_clk = sample_clk + 1'b1;
    if (level != prev_level) begin
      if (level) begin
        phase_start = sample_clk;
        key_phase   = PhHigh;
      end else begin
        if (key_phase == PhHigh) begin
          span = sample_clk - phase_start;
          if (span >= 1 && span < thr.dit_max) begin
            is_dah = 1'b0;
          end else if (span >= thr.dah_min && span < thr.dah_max) begin
            is_dah = 1'b1;
          end else begin
            rejected = 1'b1;
          end
          // A full buffer silently drops the new symbol.
          if (!rejected && n_symbols < SYMBOL_SLOTS) begin
            slots[n_symbols[3:0]] = is_dah;
            n_symbols = n_symbols + 1'b1;
          end
        end
        if (rejected) begin
          n_symbols = '0;
          key_phase = PhIdle;
        end else begin
          phase_start = sample_clk;
          key_phase   = PhLow;
        end
      end
    end else if (key_phase == PhLow || key_phase == PhChar) begin
      span = sample_clk - phase_start;
      if (span >= thr.char_gap && n_symbols != 0) begin
        word_flag = (span >= thr.word_gap);
        key_phase = PhChar;
        char_flag = 1'b1;
      end
    end
    prev_level = level;
    return report(char_flag);
  endfunction

  function automatic logic [ThrW-1:0] stored_threshold(input logic [2:0] idx);
    case (idx)
      RegDitMax:  return thr.dit_max;
      RegDahMin:  return thr.dah_min;
      RegDahMax:  return thr.dah_max;
      RegCharGap: return thr.char_gap;
      RegWordGap: return thr.word_gap;
      default:    return '0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    if (!rst_ni) begin
      thr.dit_max  = DitMaxReset;
      thr.dah_min  = DahMinReset;
      thr.dah_max  = DahMaxReset;
      thr.char_gap = CharGapReset;
      thr.word_gap = WordGapReset;
      key_phase    = PhIdle;
      sample_clk   = '0;
      phase_start  = '0;
      prev_level   = 1'b0;
      word_flag    = 1'b0;
      n_symbols    = '0;
      slots        = '0;
      awaited_reports.delete();
      fails        = 0;
    end else begin
      // The result leaving now always belongs to an earlier item, so it is
      // checked before this edge's item is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        got.char_done    = m_axis_tdata[0];
        got.word_done    = m_axis_tdata[1];
        got.symbol_total = m_axis_tdata[5:2];
        got.symbol_bits  = m_axis_tdata[13:6];
        if (awaited_reports.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = awaited_reports.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: result mismatch, expected char=%b word=%b total=%0d bits=%b,",
                     $time, want.char_done, want.word_done, want.symbol_total,
                     want.symbol_bits);
            $display("%0t:   actual char=%b word=%b total=%0d bits=%b", $time,
                     got.char_done, got.word_done, got.symbol_total, got.symbol_bits);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_reports.push_back(decode_sample(s_axis_tuser[0], s_axis_tdata[0]));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[CfgAddrW-1:2])
            RegDitMax:  thr.dit_max  = pwdata[ThrW-1:0];
            RegDahMin:  thr.dah_min  = pwdata[ThrW-1:0];
            RegDahMax:  thr.dah_max  = pwdata[ThrW-1:0];
            RegCharGap: thr.char_gap = pwdata[ThrW-1:0];
            RegWordGap: thr.word_gap = pwdata[ThrW-1:0];
            default: ;
          endcase
        end else if (prdata !== {{(CfgDataW-ThrW){1'b0}},
                                 stored_threshold(paddr[CfgAddrW-1:2])}) begin
          fails++;
          $display("%0t: register read at %h, expected %h, actual %h", $time, paddr,
                   stored_threshold(paddr[CfgAddrW-1:2]), prdata);
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= awaited_reports.size();
  end

endmodule

>>> sim/tb_morse_symbol_extractor_top.sv
// Testbench top for the Morse symbol extractor: drives key samples, clears and
// threshold writes, applies random stalls on both streams and gives the verdict.
// Depends on mse_pkg, morse_symbol_extractor_top and mse_checker.
module tb_morse_symbol_extractor_top import mse_pkg::*;;

  localparam logic ActSample  = 1'b0;
  localparam logic ActClear   = 1'b1;
  localparam int   LongHold   = 40;
  localparam int   QuietLimit = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int   fail_count;
  int   pending_count;
  int   items_sent;
  int   chars_sent;
  int   quiet_cycles;
  bit   idle_on;
  bit   long_hold_req;
  cfg_t stim_cfg;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  morse_symbol_extractor_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  mse_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // Result sink: random ready bursts, plus one long hold-off on request.
  initial begin : sink
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog, no traffic for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Short random value between lo and hi, kept near lo so runs stay brief.
  function automatic int pick(input int lo, input int hi);
    if (hi <= lo) return lo;
    return $urandom_range(lo, (hi < lo + 6) ? hi : lo + 6);
  endfunction

  task automatic push_sample(input logic act, input logic level);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {7'd0, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic key_run(input logic level, input int n);
    repeat (n) push_sample(ActSample, level);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // psel stays high between back-to-back transfers; the caller lowers it.
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input logic [7:0] dit_max, input logic [7:0] dah_min,
                                 input logic [7:0] dah_max, input logic [7:0] char_gap,
                                 input logic [7:0] word_gap);
    drain();
    stim_cfg.dit_max  = dit_max;
    stim_cfg.dah_min  = dah_min;
    stim_cfg.dah_max  = dah_max;
    stim_cfg.char_gap = char_gap;
    stim_cfg.word_gap = word_gap;
    apb_access(1'b1, RegDitMax, dit_max);
    apb_access(1'b1, RegDahMin, dah_min);
    apb_access(1'b1, RegDahMax, dah_max);
    apb_access(1'b1, RegCharGap, char_gap);
    apb_access(1'b1, RegWordGap, word_gap);
    apb_access(1'b0, RegDitMax, 8'd0);
    apb_access(1'b0, RegDahMin, 8'd0);
    apb_access(1'b0, RegDahMax, 8'd0);
    apb_access(1'b0, RegCharGap, 8'd0);
    apb_access(1'b0, RegWordGap, 8'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // One keyed character of random symbols; now and then a symbol is held too
  // long or the character is cut short by a clear.
  task automatic send_character(input int nsym);
    int dur;
    int roll;
    int gap;
    int too_long;
    too_long = (stim_cfg.dah_max > stim_cfg.dit_max) ? stim_cfg.dah_max : stim_cfg.dit_max;
    for (int k = 0; k < nsym; k++) begin
      roll = $urandom_range(0, 39);
      if (roll == 0) begin
        push_sample(ActClear, 1'($urandom_range(0, 1)));
      end
      if (roll < 2) begin
        dur = pick(too_long, 255);
      end else if (roll < 20 && stim_cfg.dit_max > 1) begin
        dur = pick(1, stim_cfg.dit_max - 1);
      end else if (stim_cfg.dah_max > stim_cfg.dah_min) begin
        dur = pick(stim_cfg.dah_min, stim_cfg.dah_max - 1);
      end else begin
        dur = pick(1, stim_cfg.dit_max - 1);
      end
      key_run(1'b1, dur);
      if (k != nsym - 1) begin
        gap = pick(1, stim_cfg.char_gap - 1);
      end else if ($urandom_range(0, 1) == 0) begin
        gap = pick(stim_cfg.char_gap, stim_cfg.word_gap);
      end else begin
        gap = pick(stim_cfg.word_gap, 255);
      end
      key_run(1'b0, gap);
    end
    chars_sent++;
  endtask

  task automatic random_phase(input int target);
    int roll;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        send_character($urandom_range(1, 10));
      end else if (roll < 90) begin
        key_run(1'($urandom_range(0, 1)), $urandom_range(1, 4));
      end else begin
        push_sample(ActClear, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    items_sent    = 0;
    chars_sent    = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b0;
    long_hold_req = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases under narrow windows.
    load_thresholds(8'd3, 8'd3, 8'd6, 8'd4, 8'd7);
    push_sample(ActClear, 1'b1);
    key_run(1'b1, 1);
    key_run(1'b0, 8);
    key_run(1'b1, 4);
    key_run(1'b0, 1);
    // Held beyond the dah window: buffer empties but the word flag survives.
    key_run(1'b1, 6);
    key_run(1'b0, 1);
    // Clear while keyed, so the falling edge arrives with no high phase.
    key_run(1'b1, 1);
    push_sample(ActClear, 1'b0);
    key_run(1'b0, 2);

    idle_on = 1'b1;
    load_thresholds(8'd3, 8'd3, 8'd7, 8'd5, 8'd9);
    random_phase(330);

    // Overlapping windows and a word gap longer than the character gap.
    load_thresholds(8'd5, 8'd2, 8'd6, 8'd3, 8'd4);
    long_hold_req = 1'b1;
    random_phase(620);

    load_thresholds(8'd1, 8'd1, 8'd255, 8'd1, 8'd1);
    random_phase(850);

    // A 256-sample high wraps to zero length; a long pause wraps past 255.
    load_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    key_run(1'b1, 2);
    key_run(1'b0, 1);
    key_run(1'b1, 256);
    key_run(1'b0, 1);
    key_run(1'b1, 3);
    key_run(1'b0, 258);

    idle_on = 1'b0;
    load_thresholds(DitMaxReset, DahMinReset, DahMaxReset, CharGapReset, WordGapReset);
    random_phase(items_sent + 60);

    drain();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d items, %0d random characters, over six threshold settings,",
             items_sent, chars_sent);
    $display("with full buffers, rejected and wrapped highs, clears and long pauses.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mse_pkg.sv
rtl/mse_cfg.sv
rtl/mse_core.sv
rtl/morse_symbol_extractor_top.sv
sim/mse_checker.sv
sim/tb_morse_symbol_extractor_top.sv
